// ----- hw/rtl/shns_pkg.sv -----
package shns_pkg;

	localparam int MAX_POINTS      = 1024;
	localparam int MAX_CELLS       = 4096;
	localparam int BUCKET_CAPACITY = 8;
	localparam int MAX_HITS        = 64;

	localparam int PT_AW   = $clog2(MAX_POINTS);
	localparam int CNT_W   = PT_AW + 1;
	localparam int CELL_AW = $clog2(MAX_CELLS);
	localparam int ENT_AW  = $clog2(BUCKET_CAPACITY);
	localparam int FILL_W  = $clog2(BUCKET_CAPACITY + 1);
	localparam int HIT_W   = $clog2(MAX_HITS + 1);
	localparam int RES_W   = 5;
	localparam int CELL_W  = 4;
	localparam int SPC_W   = 31;
	localparam int POS_W   = 32;
	localparam int RAD_W   = 31;
	localparam int IDX_W   = 10;
	localparam int CFG_AW  = 2;
	localparam int CFG_DW  = 31;
	localparam int RES_MAX = 16;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_QUERY  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_BKT_FULL   = 2'd1,
		STAT_STORE_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_RES_X   = 2'd0,
		REG_RES_Y   = 2'd1,
		REG_RES_Z   = 2'd2,
		REG_SPACING = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_CLR,
		EM_INS,
		EM_PEND,
		EM_END
	} emit_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLR,
		ST_CLR_OUT,
		ST_DIV,
		ST_FIX,
		ST_KEY,
		ST_INS,
		ST_FILL,
		ST_ENT,
		ST_PT,
		ST_DIFF,
		ST_SQ,
		ST_CMP,
		ST_END
	} state_t;

	typedef struct packed {
		logic  load;
		logic  sweep;
		logic  fix;
		logic  key_rd;
		logic  ent_rst;
		logic  ent_inc;
		logic  cell_inc;
		logic  diff;
		logic  sq;
		logic  cmp;
		emit_t emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       div_done;
		logic       sweep_done;
		logic       out_free;
		logic       fill_zero;
		logic       ent_more;
		logic       cell_last;
		logic       pi_ok;
		logic       hit;
		logic       pend_vld;
	} dp_sts_t;

	function automatic logic [RES_W-1:0] eff_res(input logic [RES_W-1:0] r);
		if (r == '0)
			return RES_W'(1);
		else if (r > RES_W'(RES_MAX))
			return RES_W'(RES_MAX);
		else
			return r;
	endfunction

endpackage

// ----- hw/rtl/shns_if.sv -----
interface shns_req_if
	import shns_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [1:0]              mode;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic [RAD_W-1:0]        radius;

	modport source(output valid, mode, pos_x, pos_y, pos_z, radius, input ready);
	modport sink(input valid, mode, pos_x, pos_y, pos_z, radius, output ready);
endinterface

interface shns_rsp_if
	import shns_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        point_index;
	logic signed [POS_W-1:0] found_x;
	logic signed [POS_W-1:0] found_y;
	logic signed [POS_W-1:0] found_z;
	logic                    hit;
	logic [1:0]              status;
	logic                    last;

	modport source(output valid, point_index, found_x, found_y, found_z, hit, status, last,
		input ready);
	modport sink(input valid, point_index, found_x, found_y, found_z, hit, status, last,
		output ready);
endinterface

interface shns_cfg_if
	import shns_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] index;
	logic [CFG_DW-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/shns_div.sv -----
module shns_div
	import shns_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [POS_W-1:0] num [3],
	input  logic [SPC_W-1:0]        den,
	input  logic [RES_W-1:0]        res [3],
	output logic                    done,
	output logic [CELL_W-1:0]       cell_w [3],
	output logic [CELL_W-1:0]       cell_n [3]
);

	logic       busy_q;
	logic [4:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31)
				busy_q <= 1'b0;
		end
	end

	assign done = !busy_q;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic             neg_q;
		logic [POS_W-1:0] quo_q;
		logic [SPC_W-1:0] rem_q;
		logic [RES_W-1:0] mod_q;
		logic [POS_W-1:0] t;
		logic             ge;
		logic [RES_W-1:0] mt;
		logic             nz;
		logic [SPC_W-1:0] rf;
		logic             half;
		logic [RES_W-1:0] mp1, mabs, w, wp1;

		// restoring divide step; quotient bits also feed a running mod-res remainder
		always_comb begin
			t  = {rem_q, quo_q[POS_W-1]};
			ge = t >= {1'b0, den};
			mt = {mod_q[RES_W-2:0], ge};
			if (mt >= res[i])
				mt = mt - res[i];
		end

		always_ff @(posedge clk) begin
			if (start) begin
				neg_q <= num[i][POS_W-1];
				quo_q <= num[i][POS_W-1] ? (~num[i] + POS_W'(1)) : num[i];
				rem_q <= '0;
				mod_q <= '0;
			end else if (busy_q) begin
				rem_q <= ge ? SPC_W'(t - {1'b0, den}) : SPC_W'(t);
				quo_q <= {quo_q[POS_W-2:0], ge};
				mod_q <= mt;
			end
		end

		always_comb begin
			nz   = rem_q != '0;
			rf   = (neg_q && nz) ? den - rem_q : rem_q;
			half = {rf, 1'b0} >= {1'b0, den};
			mp1  = (mod_q + RES_W'(1) == res[i]) ? '0 : mod_q + RES_W'(1);
			mabs = (neg_q && nz) ? mp1 : mod_q;
			w    = (!neg_q || mabs == '0) ? mabs : res[i] - mabs;
			wp1  = (w + RES_W'(1) == res[i]) ? '0 : w + RES_W'(1);
			cell_w[i] = w[CELL_W-1:0];
			if (half)
				cell_n[i] = wp1[CELL_W-1:0];
			else if (w == '0)
				cell_n[i] = CELL_W'(res[i] - RES_W'(1));
			else
				cell_n[i] = CELL_W'(w - RES_W'(1));
		end
	end

endmodule

// ----- hw/rtl/shns_dp.sv -----
module shns_dp
	import shns_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctrl_cmd_t               cmd,
	output dp_sts_t                 sts,
	input  logic                    cfg_we,
	input  logic [CFG_AW-1:0]       cfg_idx,
	input  logic [CFG_DW-1:0]       cfg_data,
	input  logic [1:0]              in_mode,
	input  logic signed [POS_W-1:0] in_x,
	input  logic signed [POS_W-1:0] in_y,
	input  logic signed [POS_W-1:0] in_z,
	input  logic [RAD_W-1:0]        in_rad,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [IDX_W-1:0]        out_idx,
	output logic signed [POS_W-1:0] out_x,
	output logic signed [POS_W-1:0] out_y,
	output logic signed [POS_W-1:0] out_z,
	output logic                    out_hit,
	output logic [1:0]              out_status,
	output logic                    out_last
);

	localparam int EADDR_W = CELL_AW + ENT_AW;
	localparam int SQ_W    = 2 * RAD_W;
	localparam int SUM_W   = SQ_W + 2;

	logic [RES_W-1:0] res_q [3];
	logic [SPC_W-1:0] spacing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q[0]  <= RES_W'(RES_MAX);
			res_q[1]  <= RES_W'(RES_MAX);
			res_q[2]  <= RES_W'(RES_MAX);
			spacing_q <= SPC_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_RES_X:   res_q[0]  <= cfg_data[RES_W-1:0];
				REG_RES_Y:   res_q[1]  <= cfg_data[RES_W-1:0];
				REG_RES_Z:   res_q[2]  <= cfg_data[RES_W-1:0];
				REG_SPACING: spacing_q <= cfg_data[SPC_W-1:0];
			endcase
		end
	end

	logic [RES_W-1:0] res_e [3];
	logic [SPC_W-1:0] spc_e;

	always_comb begin
		for (int i = 0; i < 3; i++)
			res_e[i] = eff_res(res_q[i]);
		spc_e = (spacing_q == '0) ? SPC_W'(1) : spacing_q;
	end

	// input word
	logic [1:0]              mode_q;
	logic signed [POS_W-1:0] pos_q [3];
	logic [RAD_W-1:0]        rad_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= in_mode;
			pos_q[0] <= in_x;
			pos_q[1] <= in_y;
			pos_q[2] <= in_z;
			rad_q    <= in_rad;
		end
	end

	logic signed [POS_W-1:0] div_num [3];
	logic                    div_done;
	logic [CELL_W-1:0]       div_w [3];
	logic [CELL_W-1:0]       div_n [3];

	assign div_num[0] = in_x;
	assign div_num[1] = in_y;
	assign div_num[2] = in_z;

	shns_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load),
		.num    (div_num),
		.den    (spc_e),
		.res    (res_e),
		.done   (div_done),
		.cell_w (div_w),
		.cell_n (div_n)
	);

	logic [CELL_W-1:0] cw_q [3];
	logic [CELL_W-1:0] cn_q [3];
	logic [SQ_W-1:0]   r2_q;

	always_ff @(posedge clk) begin
		if (cmd.fix) begin
			cw_q <= div_w;
			cn_q <= div_n;
			r2_q <= rad_q * rad_q;
		end
	end

	// cell walk and bucket key
	logic [2:0]         cell_q;
	logic [ENT_AW-1:0]  ent_q;
	logic [CELL_W-1:0]  cx, cy, cz;
	logic [CELL_AW-1:0] key;
	logic [CELL_AW-1:0] key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
			ent_q  <= '0;
		end else begin
			if (cmd.load)
				cell_q <= '0;
			else if (cmd.cell_inc)
				cell_q <= cell_q + 3'd1;
			if (cmd.ent_rst)
				ent_q <= '0;
			else if (cmd.ent_inc)
				ent_q <= ent_q + ENT_AW'(1);
		end
	end

	always_comb begin
		cx  = cell_q[2] ? cn_q[0] : cw_q[0];
		cy  = cell_q[1] ? cn_q[1] : cw_q[1];
		cz  = cell_q[0] ? cn_q[2] : cw_q[2];
		key = CELL_AW'((CELL_AW'(cz) * CELL_AW'(res_e[1]) + CELL_AW'(cy)) * CELL_AW'(res_e[0])
			+ CELL_AW'(cx));
	end

	always_ff @(posedge clk) begin
		if (cmd.key_rd)
			key_q <= key;
	end

	// stores
	logic [FILL_W-1:0]  fill_mem [MAX_CELLS];
	logic [IDX_W-1:0]   ent_mem [MAX_CELLS * BUCKET_CAPACITY];
	logic [3*POS_W-1:0] pt_mem [MAX_POINTS];
	logic [FILL_W-1:0]  fill_rd_q;
	logic [IDX_W-1:0]   ent_rd_q;
	logic [3*POS_W-1:0] pt_rd_q;
	logic [CELL_AW-1:0] sweep_q;
	logic [CNT_W-1:0]   count_q;

	logic out_free, push, store_full, bkt_full, ins_ok;

	assign out_free   = !out_valid || out_ready;
	assign push       = (cmd.emit != EM_NONE) && out_free;
	assign store_full = count_q >= CNT_W'(MAX_POINTS);
	assign bkt_full   = fill_rd_q >= FILL_W'(BUCKET_CAPACITY);
	assign ins_ok     = push && (cmd.emit == EM_INS) && !store_full && !bkt_full;

	always_ff @(posedge clk) begin
		if (cmd.sweep)
			fill_mem[sweep_q] <= '0;
		else if (ins_ok)
			fill_mem[key_q] <= fill_rd_q + FILL_W'(1);
		fill_rd_q <= fill_mem[key];
	end

	always_ff @(posedge clk) begin
		if (ins_ok)
			ent_mem[EADDR_W'({key_q, fill_rd_q[ENT_AW-1:0]})] <= count_q[IDX_W-1:0];
		ent_rd_q <= ent_mem[EADDR_W'({key_q, ent_q})];
	end

	always_ff @(posedge clk) begin
		if (ins_ok)
			pt_mem[count_q[PT_AW-1:0]] <= {pos_q[0], pos_q[1], pos_q[2]};
		pt_rd_q <= pt_mem[ent_rd_q[PT_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.sweep)
				sweep_q <= sweep_q + CELL_AW'(1);
			if (push && cmd.emit == EM_CLR)
				count_q <= '0;
			else if (ins_ok)
				count_q <= count_q + CNT_W'(1);
		end
	end

	// distance check
	logic [POS_W-1:0]        d_q [3];
	logic                    inbox_q, inbox2_q;
	logic [IDX_W-1:0]        cand_idx_q;
	logic signed [POS_W-1:0] cand_q [3];
	logic [SQ_W-1:0]         sq_q [3];
	logic signed [POS_W:0]   diff [3];
	logic [SUM_W-1:0]        sum;

	always_comb begin
		diff[0] = {pt_rd_q[3*POS_W-1], pt_rd_q[3*POS_W-1:2*POS_W]} - {pos_q[0][POS_W-1], pos_q[0]};
		diff[1] = {pt_rd_q[2*POS_W-1], pt_rd_q[2*POS_W-1:POS_W]} - {pos_q[1][POS_W-1], pos_q[1]};
		diff[2] = {pt_rd_q[POS_W-1], pt_rd_q[POS_W-1:0]} - {pos_q[2][POS_W-1], pos_q[2]};
	end

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			for (int i = 0; i < 3; i++)
				d_q[i] <= diff[i][POS_W] ? POS_W'(-diff[i]) : POS_W'(diff[i]);
			cand_idx_q <= ent_rd_q;
			cand_q[0]  <= pt_rd_q[3*POS_W-1:2*POS_W];
			cand_q[1]  <= pt_rd_q[2*POS_W-1:POS_W];
			cand_q[2]  <= pt_rd_q[POS_W-1:0];
		end
		if (cmd.sq) begin
			for (int i = 0; i < 3; i++)
				sq_q[i] <= d_q[i][RAD_W-1:0] * d_q[i][RAD_W-1:0];
			inbox2_q <= inbox_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.diff)
			inbox_q <=
				(diff[0][POS_W] ? POS_W'(-diff[0]) : POS_W'(diff[0])) <= {1'b0, rad_q} &&
				(diff[1][POS_W] ? POS_W'(-diff[1]) : POS_W'(diff[1])) <= {1'b0, rad_q} &&
				(diff[2][POS_W] ? POS_W'(-diff[2]) : POS_W'(diff[2])) <= {1'b0, rad_q};
	end

	assign sum = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);

	// pending hit, held back until it is known whether it is the last one
	logic                    pend_vld_q;
	logic [HIT_W-1:0]        n_q;
	logic [IDX_W-1:0]        pend_idx_q;
	logic signed [POS_W-1:0] pend_q [3];
	logic                    hit;

	assign hit = inbox2_q && (sum <= SUM_W'(r2_q)) && (n_q < HIT_W'(MAX_HITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			n_q        <= '0;
		end else if (cmd.load) begin
			pend_vld_q <= 1'b0;
			n_q        <= '0;
		end else if (cmd.cmp && hit) begin
			pend_vld_q <= 1'b1;
			n_q        <= n_q + HIT_W'(1);
		end else if (push && cmd.emit == EM_END) begin
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp && hit) begin
			pend_idx_q <= cand_idx_q;
			pend_q     <= cand_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (push)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_idx    <= '0;
			out_x      <= '0;
			out_y      <= '0;
			out_z      <= '0;
			out_hit    <= 1'b0;
			out_status <= STAT_OK;
			out_last   <= 1'b1;
			case (cmd.emit)
				EM_INS: begin
					if (store_full)
						out_status <= STAT_STORE_FULL;
					else if (bkt_full)
						out_status <= STAT_BKT_FULL;
					else
						out_idx <= count_q[IDX_W-1:0];
				end
				EM_PEND: begin
					out_idx  <= pend_idx_q;
					out_x    <= pend_q[0];
					out_y    <= pend_q[1];
					out_z    <= pend_q[2];
					out_hit  <= 1'b1;
					out_last <= 1'b0;
				end
				EM_END: begin
					if (pend_vld_q) begin
						out_idx <= pend_idx_q;
						out_x   <= pend_q[0];
						out_y   <= pend_q[1];
						out_z   <= pend_q[2];
						out_hit <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		sts            = '0;
		sts.mode       = mode_q;
		sts.div_done   = div_done;
		sts.sweep_done = sweep_q == '1;
		sts.out_free   = out_free;
		sts.fill_zero  = fill_rd_q == '0;
		sts.ent_more   = (FILL_W'(ent_q) + FILL_W'(1)) < fill_rd_q;
		sts.cell_last  = cell_q == 3'd7;
		sts.pi_ok      = CNT_W'(ent_rd_q) < count_q;
		sts.hit        = hit;
		sts.pend_vld   = pend_vld_q;
	end

endmodule

// ----- hw/rtl/shns_ctrl.sv -----
module shns_ctrl
	import shns_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_mode,
	output logic       in_ready,
	input  dp_sts_t    sts,
	output ctrl_cmd_t  cmd
);

	state_t st_q, nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_INIT;
		else
			st_q <= nxt;
	end

	always_comb begin
		nxt      = st_q;
		cmd      = '0;
		cmd.emit = EM_NONE;
		in_ready = 1'b0;
		unique case (st_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_done)
					nxt = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_mode) inside
						MODE_CLEAR:              nxt = ST_CLR;
						MODE_INSERT, MODE_QUERY: nxt = ST_DIV;
						default:                 nxt = ST_IDLE;
					endcase
				end
			end
			ST_CLR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_done)
					nxt = ST_CLR_OUT;
			end
			ST_CLR_OUT: begin
				cmd.emit = EM_CLR;
				if (sts.out_free)
					nxt = ST_IDLE;
			end
			ST_DIV: begin
				if (sts.div_done)
					nxt = ST_FIX;
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				nxt     = ST_KEY;
			end
			ST_KEY: begin
				cmd.key_rd = 1'b1;
				nxt        = (sts.mode == MODE_INSERT) ? ST_INS : ST_FILL;
			end
			ST_INS: begin
				cmd.emit = EM_INS;
				if (sts.out_free)
					nxt = ST_IDLE;
			end
			ST_FILL: begin
				if (!sts.fill_zero) begin
					cmd.ent_rst = 1'b1;
					nxt         = ST_ENT;
				end else if (sts.cell_last) begin
					nxt = ST_END;
				end else begin
					cmd.cell_inc = 1'b1;
					nxt          = ST_KEY;
				end
			end
			ST_ENT: nxt = ST_PT;
			ST_PT: begin
				if (sts.pi_ok) begin
					nxt = ST_DIFF;
				end else if (sts.ent_more) begin
					cmd.ent_inc = 1'b1;
					nxt         = ST_ENT;
				end else if (!sts.cell_last) begin
					cmd.cell_inc = 1'b1;
					nxt          = ST_KEY;
				end else begin
					nxt = ST_END;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				nxt      = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq = 1'b1;
				nxt    = ST_CMP;
			end
			ST_CMP: begin
				// a new hit pushes the held one out first
				if (sts.hit && sts.pend_vld)
					cmd.emit = EM_PEND;
				if (!(sts.hit && sts.pend_vld && !sts.out_free)) begin
					cmd.cmp = 1'b1;
					if (sts.ent_more) begin
						cmd.ent_inc = 1'b1;
						nxt         = ST_ENT;
					end else if (!sts.cell_last) begin
						cmd.cell_inc = 1'b1;
						nxt          = ST_KEY;
					end else begin
						nxt = ST_END;
					end
				end
			end
			ST_END: begin
				cmd.emit = EM_END;
				if (sts.out_free)
					nxt = ST_IDLE;
			end
			default: nxt = ST_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/spatial_hash_neighbor_search_core.sv -----
// 3-D hashed point grid with neighbor query, signed Q16.16 coordinates. After reset the
// block zeroes the bucket fill table before it takes a word; a clear word runs the same
// sweep, then returns one word. Insert waits on the 32-step divider that finds the cell
// on all three axes at once. A query walks 8 cells, and each bucket entry walked goes in
// turn through the entry memory, the point memory, the squaring multipliers and the
// distance compare. Up to 64 hit words come out per query, the last one flagged; a query
// with no hit gives one word. A new word is taken once the previous one is finished,
// while its last result may still wait in the output register.
module spatial_hash_neighbor_search_core
	import shns_pkg::*;
(
	input logic clk,
	input logic arst_n,
	shns_req_if.sink   req,
	shns_rsp_if.source rsp,
	shns_cfg_if.sink   cfg
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	assign cfg.ready = 1'b1;

	shns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_mode  (req.mode),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	shns_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg.valid),
		.cfg_idx    (cfg.index),
		.cfg_data   (cfg.data),
		.in_mode    (req.mode),
		.in_x       (req.pos_x),
		.in_y       (req.pos_y),
		.in_z       (req.pos_z),
		.in_rad     (req.radius),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_idx    (rsp.point_index),
		.out_x      (rsp.found_x),
		.out_y      (rsp.found_y),
		.out_z      (rsp.found_z),
		.out_hit    (rsp.hit),
		.out_status (rsp.status),
		.out_last   (rsp.last)
	);

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import shns_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [IDX_W-1:0]        idx;
		logic signed [POS_W-1:0] fx;
		logic signed [POS_W-1:0] fy;
		logic signed [POS_W-1:0] fz;
		logic                    hit;
		logic [1:0]              status;
		logic                    last;
	} word_t;

	typedef struct {
		logic [1:0]              md;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic [RAD_W-1:0]        r;
		bit                      typed;
		word_t                   want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	shns_req_if req ();
	shns_rsp_if rsp ();
	shns_cfg_if cfg ();

	spatial_hash_neighbor_search_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	always #1 clk = ~clk;

	// grid copy kept by the testbench
	logic [RES_W-1:0] grid_res [3];
	logic [SPC_W-1:0] grid_spc;
	int  pt_x [MAX_POINTS];
	int  pt_y [MAX_POINTS];
	int  pt_z [MAX_POINTS];
	int  pt_count;
	int  cell_fill [MAX_CELLS];
	int  cell_slot [MAX_CELLS*BUCKET_CAPACITY];

	word_t pending_words [$];
	int    errors = 0;
	int    items_sent = 0;
	int    words_seen = 0;
	int    hits_seen = 0;
	bit    calm = 1'b0;
	bit    hold_go = 1'b0;
	bit    hold_done = 1'b0;
	int    hold_left = 0;

	// positions sent with insert words, used to aim queries
	int aim_x [$];
	int aim_y [$];
	int aim_z [$];

	function automatic longint res_of(logic [RES_W-1:0] r);
		if (r == 0)
			return 1;
		if (r > RES_MAX)
			return RES_MAX;
		return r;
	endfunction

	function automatic longint spacing_of();
		return (grid_spc == 0) ? 1 : longint'(grid_spc);
	endfunction

	function automatic longint floor_q(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function automatic longint wrap_cell(longint c, longint r);
		longint m;
		m = c % r;
		if (m < 0)
			m += r;
		return m;
	endfunction

	function automatic int bucket_of(longint cx, longint cy, longint cz);
		longint rx, ry, rz, k;
		rx = res_of(grid_res[0]);
		ry = res_of(grid_res[1]);
		rz = res_of(grid_res[2]);
		k = (wrap_cell(cz, rz) * ry + wrap_cell(cy, ry)) * rx + wrap_cell(cx, rx);
		return int'(k % MAX_CELLS);
	endfunction

	function automatic longint unsigned dist1(longint a, longint b);
		return (a >= b) ? longint'(a - b) : longint'(b - a);
	endfunction

	function automatic word_t mk_word(int idx, int fx, int fy, int fz, int hit,
		status_t st, int last);
		word_t w;
		w.idx = idx[IDX_W-1:0];
		w.fx = fx;
		w.fy = fy;
		w.fz = fz;
		w.hit = hit[0];
		w.status = st;
		w.last = last[0];
		return w;
	endfunction

	function automatic void grid_step(logic [1:0] md, logic signed [POS_W-1:0] x,
		logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z, logic [RAD_W-1:0] r,
		output word_t outs [$]);
		longint px, py, pz, s, ox, oy, oz, sx, sy, sz, cx, cy, cz;
		longint unsigned dx, dy, dz, r2, rr;
		int key, fill, pi, n;
		outs = {};
		px = x;
		py = y;
		pz = z;
		s = spacing_of();
		ox = floor_q(px, s);
		oy = floor_q(py, s);
		oz = floor_q(pz, s);
		rr = r;
		case (md)
			MODE_CLEAR: begin
				pt_count = 0;
				foreach (cell_fill[i])
					cell_fill[i] = 0;
				outs = {outs, mk_word(0, 0, 0, 0, 0, STAT_OK, 1)};
			end
			MODE_INSERT: begin
				key = bucket_of(ox, oy, oz);
				if (pt_count >= MAX_POINTS)
					outs = {outs, mk_word(0, 0, 0, 0, 0, STAT_STORE_FULL, 1)};
				else if (cell_fill[key] >= BUCKET_CAPACITY)
					outs = {outs, mk_word(0, 0, 0, 0, 0, STAT_BKT_FULL, 1)};
				else begin
					pt_x[pt_count] = x;
					pt_y[pt_count] = y;
					pt_z[pt_count] = z;
					cell_slot[key*BUCKET_CAPACITY + cell_fill[key]] = pt_count;
					cell_fill[key]++;
					outs = {outs, mk_word(pt_count, 0, 0, 0, 0, STAT_OK, 1)};
					pt_count++;
				end
			end
			MODE_QUERY: begin
				sx = ((2*ox + 1) * s <= 2*px) ? 1 : -1;
				sy = ((2*oy + 1) * s <= 2*py) ? 1 : -1;
				sz = ((2*oz + 1) * s <= 2*pz) ? 1 : -1;
				r2 = rr * rr;
				n = 0;
				for (int c = 0; c < 8; c++) begin
					cx = ox + (c[2] ? sx : 0);
					cy = oy + (c[1] ? sy : 0);
					cz = oz + (c[0] ? sz : 0);
					key = bucket_of(cx, cy, cz);
					fill = cell_fill[key];
					for (int j = 0; j < fill; j++) begin
						pi = cell_slot[key*BUCKET_CAPACITY + j];
						if (pi >= pt_count)
							continue;
						dx = dist1(pt_x[pi], px);
						dy = dist1(pt_y[pi], py);
						dz = dist1(pt_z[pi], pz);
						if (dx > rr || dy > rr || dz > rr)
							continue;
						if (dx*dx + dy*dy + dz*dz <= r2 && n < MAX_HITS) begin
							outs = {outs, mk_word(pi, pt_x[pi], pt_y[pi], pt_z[pi], 1,
								STAT_OK, 0)};
							n++;
						end
					end
				end
				if (n == 0)
					outs = {outs, mk_word(0, 0, 0, 0, 0, STAT_OK, 1)};
				else
					outs[n-1].last = 1'b1;
			end
			default: ;
		endcase
	endfunction

	task automatic mismatch(string what, longint got, longint want);
		errors++;
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
	endtask

	// result word checker
	always @(posedge clk) begin
		word_t w;
		if (rsp.valid && rsp.ready) begin
			words_seen++;
			if (rsp.hit)
				hits_seen++;
			if (pending_words.size() == 0)
				mismatch("unexpected word", rsp.point_index, 0);
			else begin
				w = pending_words.pop_front();
				if (rsp.point_index !== w.idx) mismatch("point_index", rsp.point_index, w.idx);
				if (rsp.found_x !== w.fx) mismatch("found_x", rsp.found_x, w.fx);
				if (rsp.found_y !== w.fy) mismatch("found_y", rsp.found_y, w.fy);
				if (rsp.found_z !== w.fz) mismatch("found_z", rsp.found_z, w.fz);
				if (rsp.hit !== w.hit) mismatch("hit", rsp.hit, w.hit);
				if (rsp.status !== w.status) mismatch("status", rsp.status, w.status);
				if (rsp.last !== w.last) mismatch("last", rsp.last, w.last);
			end
		end
	end

	// result side backpressure, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_go && !hold_done) begin
			hold_left <= 600;
			hold_done <= 1'b1;
			rsp.ready <= 1'b0;
		end else begin
			if (hold_left > 0)
				hold_left <= hold_left - 1;
			rsp.ready <= (hold_left <= 1) && (calm || $urandom_range(99) >= 13);
		end
	end

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 13);
	endfunction

	task automatic send(logic [1:0] md, logic signed [POS_W-1:0] x,
		logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z, logic [RAD_W-1:0] r,
		bit typed, word_t want);
		word_t outs [$];
		while (idle_now()) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= md;
		req.pos_x <= x;
		req.pos_y <= y;
		req.pos_z <= z;
		req.radius <= r;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		grid_step(md, x, y, z, r, outs);
		if (typed)
			pending_words = {pending_words, want};
		else
			pending_words = {pending_words, outs};
		if (md == MODE_INSERT) begin
			aim_x = {aim_x, x};
			aim_y = {aim_y, y};
			aim_z = {aim_z, z};
		end
		items_sent++;
	endtask

	task automatic go(logic [1:0] md, int x, int y, int z, logic [RAD_W-1:0] r);
		send(md, x, y, z, r, 1'b0, '0);
	endtask

	// drain all results, then leave time for a word that makes none
	task automatic settle();
		req.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t ri, logic [CFG_DW-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= ri;
		cfg.data <= d;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		case (ri)
			REG_RES_X:   grid_res[0] = d[RES_W-1:0];
			REG_RES_Y:   grid_res[1] = d[RES_W-1:0];
			REG_RES_Z:   grid_res[2] = d[RES_W-1:0];
			REG_SPACING: grid_spc = d[SPC_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_grid(int rx, int ry, int rz, logic [CFG_DW-1:0] spc);
		settle();
		write_reg(REG_RES_X, CFG_DW'(rx));
		write_reg(REG_RES_Y, CFG_DW'(ry));
		write_reg(REG_RES_Z, CFG_DW'(rz));
		write_reg(REG_SPACING, spc);
		cfg.valid <= 1'b0;
	endtask

	function automatic int near_grid();
		longint s, v;
		s = spacing_of();
		v = longint'($urandom_range(0, 20)) - 4;
		v = v * s + longint'($urandom % s);
		return int'(v);
	endfunction

	task automatic random_mix(int n);
		int pick, k, off;
		logic [RAD_W-1:0] r;
		longint s;
		s = spacing_of();
		go(MODE_CLEAR, 0, 0, 0, 0);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (s > 64'h3fff_ffff)
				r = RAD_W'($urandom);
			else
				r = RAD_W'($urandom_range(0, int'(2*s)));
			if (pick < 40)
				go(MODE_INSERT, near_grid(), near_grid(), near_grid(), RAD_W'($urandom));
			else if (pick < 85 && aim_x.size() != 0) begin
				k = $urandom_range(0, aim_x.size() - 1);
				off = (s > 64'h0fff_ffff) ? $urandom : int'($urandom % s) - int'(s / 2);
				go(MODE_QUERY, aim_x[k] + off, aim_y[k] - off / 2, aim_z[k], r);
			end else if (pick < 88)
				go(MODE_CLEAR, $urandom, $urandom, $urandom, RAD_W'($urandom));
			else if (pick < 91)
				go(MODE_UNUSED, $urandom, $urandom, $urandom, RAD_W'($urandom));
			else
				go(2'($urandom_range(1, 2)), $urandom, $urandom, $urandom,
					RAD_W'($urandom));
		end
	endtask

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		row_t steps [$];
		row_t rw;
		word_t none;
		none = mk_word(0, 0, 0, 0, 0, STAT_OK, 1);
		grid_res = '{5'd16, 5'd16, 5'd16};
		grid_spc = 31'd65536;
		pt_count = 0;
		foreach (cell_fill[i])
			cell_fill[i] = 0;
		req.valid = 1'b0;
		req.mode = MODE_CLEAR;
		req.pos_x = '0;
		req.pos_y = '0;
		req.pos_z = '0;
		req.radius = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_RES_X;
		cfg.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed table: typed rows carry their expected word
		steps = {steps, row_t'{MODE_CLEAR, 5, 6, 7, 9, 1, none}};
		steps = {steps, row_t'{MODE_QUERY, 0, 0, 0, 31'h7fff_ffff, 1, none}};
		steps = {steps, row_t'{MODE_INSERT, 0, 0, 0, 0, 1,
			mk_word(0, 0, 0, 0, 0, STAT_OK, 1)}};
		steps = {steps, row_t'{MODE_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 1,
			mk_word(1, 0, 0, 0, 0, STAT_OK, 1)}};
		steps = {steps, row_t'{MODE_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1,
			mk_word(2, 0, 0, 0, 0, STAT_OK, 1)}};
		steps = {steps, row_t'{MODE_INSERT, -1, -1, -1, 0, 1,
			mk_word(3, 0, 0, 0, 0, STAT_OK, 1)}};
		steps = {steps, row_t'{MODE_QUERY, 0, 0, 0, 31'h7fff_ffff, 0, none}};
		steps = {steps, row_t'{MODE_QUERY, -1, -1, -1, 0, 0, none}};
		steps = {steps, row_t'{MODE_QUERY, 32'h7fff_ffff, 32'h7fff_fff0, 32'h7fff_ffff,
			31'h20, 0, none}};
		steps = {steps, row_t'{MODE_UNUSED, 1, 2, 3, 4, 0, none}};
		// nine points in one cell: the last overflows its bucket
		for (int i = 0; i < 9; i++) begin
			rw = '{MODE_INSERT, 32'h18000 + i, 32'h28000, 32'h8000, 0, 0, none};
			if (i == 8) begin
				rw.typed = 1'b1;
				rw.want = mk_word(0, 0, 0, 0, 0, STAT_BKT_FULL, 1);
			end
			steps = {steps, rw};
		end
		steps = {steps, row_t'{MODE_QUERY, 32'h18004, 32'h28000, 32'h8000, 31'h10000, 0,
			none}};
		steps = {steps, row_t'{MODE_QUERY, 32'h1ffff, 32'h20000, 32'h8000, 31'h7fff_ffff, 0,
			none}};
		steps = {steps, row_t'{MODE_CLEAR, 0, 0, 0, 0, 1, none}};
		foreach (steps[i]) begin
			// long result hold-off while the inserts keep coming
			if (i == 10)
				hold_go <= 1'b1;
			send(steps[i].md, steps[i].x, steps[i].y, steps[i].z, steps[i].r,
				steps[i].typed, steps[i].want);
		end

		random_mix(80);

		set_grid(1, 1, 1, 0);
		random_mix(60);
		set_grid(0, 17, 31, 31'h7fff_ffff);
		random_mix(50);
		set_grid(3, 5, 7, 31'h8000);
		random_mix(80);
		set_grid(16, 16, 16, 1);
		random_mix(60);

		// inserts and a query back to back, without idling
		set_grid(16, 16, 16, 31'h10000);
		calm = 1'b1;
		go(MODE_CLEAR, 0, 0, 0, 0);
		for (int i = 0; i < 20; i++)
			go(MODE_INSERT, (i & 3) << 16, ((i >> 2) & 3) << 16, 32'h8000, 0);
		go(MODE_QUERY, 32'h18000, 32'h18000, 32'h8000, 31'h20000);
		calm = 1'b0;

		set_grid(2, 16, 9, 31'h30000);
		random_mix(80);

		settle();
		$display("%0d words sent under seven grid setups, %0d results checked, %0d hits",
			items_sent, words_seen, hits_seen);
		$display("covered clear, insert, query, full bucket, unused mode, long output stall");
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/shns_pkg.sv
hw/rtl/shns_if.sv
hw/rtl/shns_div.sv
hw/rtl/shns_dp.sv
hw/rtl/shns_ctrl.sv
hw/rtl/spatial_hash_neighbor_search_core.sv
dv/tb_top.sv
